// ----- sv/vab_pkg.sv -----
// Shared types, constants and the arctangent table for the vector angle block.
package vab_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int TURN_WIDTH = 32;
    localparam int TABLE_LEN  = 32;
    localparam int MAX_EFF    = 30;
    localparam int GUARD_BASE = 61;

    localparam logic [TURN_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [TURN_WIDTH-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic [TURN_WIDTH-1:0]        z;
        logic                         bypass;
    } cordic_t;

    function automatic int eff_width(input int cw);
        return (cw > MAX_EFF) ? MAX_EFF : cw;
    endfunction

    function automatic int eff_shift(input int cw);
        return (cw > MAX_EFF) ? (cw - MAX_EFF) : 0;
    endfunction

endpackage

// ----- sv/vab_product.sv -----
// Two pipeline stages that form the cross product and the dot product of the vectors.
module vab_product import vab_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int EW = eff_width(COORD_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] target_x,
    input  logic signed [COORD_WIDTH-1:0] target_y,
    input  logic signed [COORD_WIDTH-1:0] base_x,
    input  logic signed [COORD_WIDTH-1:0] base_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [2*EW:0]          det,
    output logic signed [2*EW:0]          dot
);

    localparam int SHIFT = eff_shift(COORD_WIDTH);

    logic signed [COORD_WIDTH-1:0] tx_sh, ty_sh, bx_sh, by_sh;
    logic signed [EW-1:0]          tx, ty, bx, by;
    logic signed [2*EW-1:0]        prod_next [4];
    logic signed [2*EW-1:0]        prod_reg  [4];
    logic                          valid1_reg, valid2_reg;
    logic                          ready1, ready2;
    logic signed [2*EW:0]          det_next, dot_next, det_reg, dot_reg;

    assign tx_sh = target_x >>> SHIFT;
    assign ty_sh = target_y >>> SHIFT;
    assign bx_sh = base_x >>> SHIFT;
    assign by_sh = base_y >>> SHIFT;

    assign tx = signed'(tx_sh[EW-1:0]);
    assign ty = signed'(ty_sh[EW-1:0]);
    assign bx = signed'(bx_sh[EW-1:0]);
    assign by = signed'(by_sh[EW-1:0]);

    always_comb begin
        prod_next[0] = tx * by;
        prod_next[1] = ty * bx;
        prod_next[2] = tx * bx;
        prod_next[3] = ty * by;
    end

    assign ready2   = !valid2_reg || out_ready;
    assign ready1   = !valid1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (ready1) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign det_next = (2*EW+1)'(prod_reg[0]) - (2*EW+1)'(prod_reg[1]);
    assign dot_next = (2*EW+1)'(prod_reg[2]) + (2*EW+1)'(prod_reg[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (ready2) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && valid1_reg) begin
            det_reg <= det_next;
            dot_reg <= dot_next;
        end
    end

    assign out_valid = valid2_reg;
    assign det       = det_reg;
    assign dot       = dot_reg;

endmodule

// ----- sv/vab_prep.sv -----
// Scales the products, handles the degenerate cases and folds the left half plane.
module vab_prep import vab_pkg::*; #(
    parameter int COORD_WIDTH = 16,
    parameter int EW = eff_width(COORD_WIDTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [2*EW:0] det,
    input  logic signed [2*EW:0] dot,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cordic_t              out_data
);

    localparam int GUARD = GUARD_BASE - 2*EW;

    logic signed [DATA_WIDTH-1:0] x_sc, y_sc;
    cordic_t                      data_next, data_reg;
    logic                         valid_reg;

    assign x_sc = DATA_WIDTH'(dot) <<< GUARD;
    assign y_sc = DATA_WIDTH'(det) <<< GUARD;

    always_comb begin
        data_next.x      = x_sc;
        data_next.y      = y_sc;
        data_next.z      = '0;
        data_next.bypass = 1'b0;
        if (det == '0) begin
            data_next.bypass = 1'b1;
            data_next.z      = dot[2*EW] ? HALF_TURN : '0;
        end else if (dot[2*EW]) begin
            data_next.x = -x_sc;
            data_next.y = -y_sc;
            data_next.z = HALF_TURN;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/vab_cordic_stage.sv -----
// One registered CORDIC vectoring iteration with a fixed shift.
module vab_cordic_stage import vab_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    logic signed [DATA_WIDTH-1:0] x_in, y_in, xs, ys;
    cordic_t                      data_next, data_reg;
    logic                         valid_reg;

    assign x_in = in_data.x;
    assign y_in = in_data.y;
    assign xs   = x_in >>> STEP;
    assign ys   = y_in >>> STEP;

    always_comb begin
        data_next = in_data;
        if (!in_data.bypass) begin
            if (!y_in[DATA_WIDTH-1]) begin
                data_next.x = x_in + ys;
                data_next.y = y_in - xs;
                data_next.z = in_data.z + ATAN_TABLE[STEP];
            end else begin
                data_next.x = x_in - ys;
                data_next.y = y_in + xs;
                data_next.z = in_data.z - ATAN_TABLE[STEP];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/vab_round.sv -----
// Output register that rounds the turn fraction to the result width.
module vab_round import vab_pkg::*; #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [TURN_WIDTH-1:0]  z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ANGLE_WIDTH-1:0] angle
);

    localparam int                  DROP = TURN_WIDTH - ANGLE_WIDTH;
    localparam logic [TURN_WIDTH:0] RND  = ((TURN_WIDTH+1)'(1) << DROP) >> 1;

    logic [TURN_WIDTH:0]    sum;
    logic [ANGLE_WIDTH-1:0] angle_next, angle_reg;
    logic                   valid_reg;

    assign sum        = {1'b0, z} + RND;
    assign angle_next = sum[DROP +: ANGLE_WIDTH];
    assign in_ready   = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;

endmodule

// ----- sv/vector_angle_between.sv -----
// Top level of the pipelined angle unit between a base and a target vector.
// The pipeline has two product stages, one scaling stage, one stage per CORDIC
// iteration and the rounding output register.
// Throughput is one request per cycle while m_ready is high; each stage holds its request under backpressure.
// Reset is synchronous and active low and clears only the stage valid bits.
module vector_angle_between import vab_pkg::*; #(
    parameter int COORD_WIDTH  = 16,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_target_x,
    input  logic signed [COORD_WIDTH-1:0] s_target_y,
    input  logic signed [COORD_WIDTH-1:0] s_base_x,
    input  logic signed [COORD_WIDTH-1:0] s_base_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ANGLE_WIDTH-1:0]        m_turn_angle
);

    localparam int EW = eff_width(COORD_WIDTH);

    logic                 prod_valid, prod_ready;
    logic signed [2*EW:0] det, dot;
    logic [CORDIC_STEPS:0] c_valid, c_ready;
    cordic_t               c_data [CORDIC_STEPS+1];

    vab_product #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .target_x  (s_target_x),
        .target_y  (s_target_y),
        .base_x    (s_base_x),
        .base_y    (s_base_y),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .det       (det),
        .dot       (dot)
    );

    vab_prep #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .det       (det),
        .dot       (dot),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_data  (c_data[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        vab_cordic_stage #(
            .STEP(i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_data   (c_data[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_data  (c_data[i+1])
        );
    end

    vab_round #(
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid[CORDIC_STEPS]),
        .in_ready  (c_ready[CORDIC_STEPS]),
        .z         (c_data[CORDIC_STEPS].z),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .angle     (m_turn_angle)
    );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the vector angle unit, with randomized stimulus and flow control.
`timescale 1ns / 100ps

module tb;

    localparam int COORD_W     = 16;
    localparam int ANGLE_W     = 16;
    localparam int STEPS       = 16;
    localparam int LATENCY     = STEPS + 4;
    localparam int EFF_SHIFT   = (COORD_W > 30) ? (COORD_W - 30) : 0;
    localparam int EFF_W       = (COORD_W > 30) ? 30 : COORD_W;
    localparam int GUARD       = 61 - 2 * EFF_W;
    localparam int TURN_DROP   = 32 - ANGLE_W;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_PRINTED = 40;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [32:0] ROUND_HALF = (33'd1 << TURN_DROP) >> 1;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_target_x = '0;
    logic signed [COORD_W-1:0] s_target_y = '0;
    logic signed [COORD_W-1:0] s_base_x = '0;
    logic signed [COORD_W-1:0] s_base_y = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [ANGLE_W-1:0]        m_turn_angle;

    logic [ANGLE_W-1:0] angle_q [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int unsigned        send_idle = 0;
    int unsigned        recv_idle = 0;
    int                 hold_token = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 stall_cycles = 0;

    vector_angle_between #(
        .COORD_WIDTH (COORD_W),
        .ANGLE_WIDTH (ANGLE_W),
        .CORDIC_STEPS(STEPS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_target_x  (s_target_x),
        .s_target_y  (s_target_y),
        .s_base_x    (s_base_x),
        .s_base_y    (s_base_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_turn_angle(m_turn_angle)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [ANGLE_W-1:0] predict_turn(
        input logic signed [COORD_W-1:0] tx, ty, bx, by);
        longint      ax, ay, cx, cy, det, dot, px, py, sx, sy;
        logic [31:0] acc;
        logic [32:0] rounded;
        ax = longint'(tx) >>> EFF_SHIFT;
        ay = longint'(ty) >>> EFF_SHIFT;
        cx = longint'(bx) >>> EFF_SHIFT;
        cy = longint'(by) >>> EFF_SHIFT;
        det = ax * cy - ay * cx;
        dot = ax * cx + ay * cy;
        if (det == 0) begin
            acc = (dot < 0) ? HALF_TURN : 32'd0;
        end else begin
            px = dot * (longint'(1) <<< GUARD);
            py = det * (longint'(1) <<< GUARD);
            acc = 32'd0;
            if (px < 0) begin
                px = -px;
                py = -py;
                acc = HALF_TURN;
            end
            for (int i = 0; i < STEPS && i < 32; i++) begin
                sx = px >>> i;
                sy = py >>> i;
                if (py >= 0) begin
                    px = px + sy;
                    py = py - sx;
                    acc = acc + ATAN_TURNS[i];
                end else begin
                    px = px - sy;
                    py = py + sx;
                    acc = acc - ATAN_TURNS[i];
                end
            end
        end
        rounded = ({1'b0, acc} + ROUND_HALF) >> TURN_DROP;
        return rounded[ANGLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [ANGLE_W-1:0] got,
                                   input logic [ANGLE_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: result %0d %s: got %h expected %h", $time, results_seen, what,
                     got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (angle_q.size() == 0)
                    report_mismatch("arrived with no request pending", m_turn_angle, '0);
                else if (m_turn_angle !== angle_q[0])
                    report_mismatch("turn_angle differs", m_turn_angle, angle_q.pop_front());
                else
                    void'(angle_q.pop_front());
            end
            if (s_valid && s_ready)
                angle_q.push_back(predict_turn(s_target_x, s_target_y, s_base_x, s_base_y));
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // The receiver honors a long hold-off when a test asks for one, otherwise it idles at random.
    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic offer_vectors(input logic signed [COORD_W-1:0] tx, ty, bx, by);
        @(negedge aclk);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_target_x <= tx;
        s_target_y <= ty;
        s_base_x   <= bx;
        s_base_y   <= by;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] pick_extreme();
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    task automatic test_directed();
        offer_vectors(0, 0, 0, 0);
        offer_vectors(0, 0, 1234, -567);
        offer_vectors(100, 200, 300, 600);
        offer_vectors(100, 200, -50, -100);
        offer_vectors(32767, 0, 32767, 0);
        offer_vectors(-32768, -32768, -32768, -32768);
        offer_vectors(-32768, 32767, -32768, -32768);
        offer_vectors(32767, -32768, -32768, 32767);
        offer_vectors(0, 1000, 1000, 0);
        offer_vectors(0, -1000, 1000, 0);
        offer_vectors(-1000, 1, 1000, 0);
        offer_vectors(-1000, -1, 1000, 0);
        offer_vectors(32767, -1, 32767, 0);
        offer_vectors(32767, 1, 32767, 0);
        offer_vectors(-32768, 0, 32767, 0);
        offer_vectors(1, 1, -1, 1);
        offer_vectors(1, 0, 0, -1);
        offer_vectors(32767, 32767, -32768, -32768);
        offer_vectors(32767, 32767, 32767, 32767);
        offer_vectors(-1, -1, -1, -1);
        offer_vectors(12345, -23456, -30000, 7000);
        idle_input();
    endtask

    task automatic test_random_pairs(input int count);
        logic signed [COORD_W-1:0] tx, ty, bx, by;
        int                        k;
        for (int n = 0; n < count; n++) begin
            tx = 16'($urandom);
            ty = 16'($urandom);
            bx = 16'($urandom);
            by = 16'($urandom);
            case ($urandom_range(9))
                5: begin
                    tx = 16'($urandom_range(16) - 8);
                    ty = 16'($urandom_range(16) - 8);
                    bx = 16'($urandom_range(16) - 8);
                    by = 16'($urandom_range(16) - 8);
                end
                6: begin
                    k  = int'($urandom_range(16)) - 8;
                    tx = 16'(int'($urandom_range(8000)) - 4000);
                    ty = 16'(int'($urandom_range(8000)) - 4000);
                    bx = 16'(k * tx);
                    by = 16'(k * ty);
                end
                7: begin
                    tx = pick_extreme();
                    ty = pick_extreme();
                    bx = pick_extreme();
                    by = pick_extreme();
                end
                8: begin
                    tx = 16'(int'($urandom_range(65534)) - 32767);
                    ty = 16'(int'($urandom_range(65534)) - 32767);
                    bx = $urandom_range(1) ? -ty : ty;
                    by = (bx == -ty) ? tx : -tx;
                end
                9: begin
                    if ($urandom_range(1)) begin
                        tx = '0;
                        ty = '0;
                    end else begin
                        bx = '0;
                        by = '0;
                    end
                end
                default: ;
            endcase
            offer_vectors(tx, ty, bx, by);
        end
        idle_input();
    endtask

    task automatic test_backpressure(input int count);
        hold_token++;
        for (int n = 0; n < count; n++)
            offer_vectors(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        idle_input();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle = 9;
        recv_idle = 88;
        test_directed();
        test_random_pairs(200);

        send_idle = 88;
        recv_idle = 9;
        test_random_pairs(200);

        send_idle = 0;
        recv_idle = 0;
        test_random_pairs(200);
        test_backpressure(60);

        while (angle_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
